@@ rtl/sbob_pkg.sv @@
// shared constants and types of the oscillator bank
package sbob_pkg;

	// bank size and channel index width
	localparam int CHANNELS = 10;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// operation codes of an input item
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// reflection bounds of the position
	localparam logic signed [15:0] POS_LIMIT  = 16'sh0500;
	localparam logic signed [15:0] POS_CLAMP  = 16'sh04FF;
	localparam logic signed [15:0] POS_MIRROR = 16'sh0A00;

	// one entry of the channel store
	typedef struct packed {
		logic signed [15:0] position;
		logic signed [15:0] speed;
		logic signed [15:0] target;
		logic signed [7:0]  direction;
	} chan_t;

	// read issued into the update pipeline
	typedef struct packed {
		logic            valid;
		logic [CH_W-1:0] idx;
	} slot_t;

	// finished channel leaving the update pipeline
	typedef struct packed {
		logic            valid;
		logic [CH_W-1:0] idx;
		chan_t           data;
	} wback_t;

endpackage

@@ rtl/sbob_store.sv @@
// channel state memory with one write port, one registered read port and valid bits
module sbob_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    we,
	input  logic [sbob_pkg::CH_W-1:0] waddr,
	input  sbob_pkg::chan_t         wdata,
	input  logic                    re,
	input  logic [sbob_pkg::CH_W-1:0] raddr,
	output sbob_pkg::chan_t         rdata
);

	sbob_pkg::chan_t                  mem_q [sbob_pkg::CHANNELS];
	logic [sbob_pkg::CHANNELS-1:0]    valid_q;
	sbob_pkg::chan_t                  rd_q;
	logic                             rd_valid_q;

	// memory array, synchronous read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	// entries read as zero until written after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

@@ rtl/sbob_calc.sv @@
// four stage channel update: slew, direction multiply, gain multiply, move and reflect
module sbob_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  sbob_pkg::slot_t    issue,
	input  logic [7:0]         slew_rate,
	input  logic [3:0]         speed_gain,
	input  sbob_pkg::chan_t    rdata,
	output sbob_pkg::wback_t   wb,
	output logic               busy
);

	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic [sbob_pkg::CH_W-1:0]     idx_s1, idx_s2, idx_s3, idx_s4;
	sbob_pkg::chan_t               ch_s2, ch_s3, ch_s4;
	logic [15:0]                   prod_s3;
	logic [15:0]                   move_s4;

	logic signed [15:0] cur;
	logic signed [15:0] tgt;
	logic signed [16:0] aim;
	logic signed [17:0] diff;
	logic [17:0]        mag;
	logic [17:0]        step_w;
	logic [15:0]        step16;
	logic signed [15:0] slewed;
	sbob_pkg::chan_t    slew_ch;
	logic signed [23:0] prod_dir;
	logic [19:0]        prod_gain;
	logic signed [15:0] pos_sum;
	logic signed [15:0] pos_new;
	logic               flip;

	// stage 1: slew the speed toward its aim
	always_comb begin
		cur    = rdata.speed;
		tgt    = rdata.target;
		aim    = cur[15] ? -17'(tgt) : 17'(tgt);
		diff   = 18'(aim) - 18'(cur);
		mag    = diff[17] ? 18'(-diff) : 18'(diff);
		step16 = {4'b0, slew_rate, 4'b0};
		step_w = {2'b0, step16};
		if (cur == tgt) begin
			slewed = cur;
		end else if (mag < step_w) begin
			slewed = aim[15:0];
		end else if (diff[17]) begin
			slewed = cur - $signed(step16);
		end else begin
			slewed = cur + $signed(step16);
		end
		slew_ch       = rdata;
		slew_ch.speed = slewed;
	end

	// stage 2 and 3: low product bits are all the 16-bit wrap needs
	assign prod_dir  = ch_s2.speed * ch_s2.direction;
	assign prod_gain = prod_s3 * speed_gain;

	// stage 4: move, then reflect off the bounds
	always_comb begin
		pos_sum = ch_s4.position + $signed(move_s4);
		pos_new = pos_sum;
		flip    = 1'b0;
		if (pos_sum >= sbob_pkg::POS_LIMIT) begin
			pos_new = sbob_pkg::POS_MIRROR - pos_sum;
			flip    = 1'b1;
			if (pos_new >= sbob_pkg::POS_LIMIT) begin
				pos_new = sbob_pkg::POS_CLAMP;
			end
		end else if (pos_sum < 16'sd0) begin
			pos_new = -pos_sum;
			flip    = 1'b1;
			if (pos_new < 16'sd0) begin
				pos_new = 16'sd0;
			end
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= issue.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1       <= issue.idx;
			idx_s2       <= idx_s1;
			ch_s2        <= slew_ch;
			idx_s3       <= idx_s2;
			ch_s3        <= ch_s2;
			prod_s3      <= prod_dir[15:0];
			idx_s4       <= idx_s3;
			ch_s4        <= ch_s3;
			move_s4      <= prod_gain[15:0];
		end
	end

	// finished channel for write back and output
	always_comb begin
		wb.valid          = valid_s4;
		wb.idx            = idx_s4;
		wb.data           = ch_s4;
		wb.data.position  = pos_new;
		wb.data.direction = flip ? -ch_s4.direction : ch_s4.direction;
	end

	assign busy = valid_s1 | valid_s2 | valid_s3 | valid_s4;

endmodule

@@ rtl/slewed_bouncing_oscillator_bank.sv @@
// top level of the slewed bouncing oscillator bank
//
// Usage: items arrive on the item channel (item_valid / item_stall) and
// results leave on the result channel (result_valid / result_stall); a
// transfer happens on a clock edge with valid high and stall low.
// A write item loads position, speed, target and direction of one channel
// in the cycle of its transfer and gives no result; a channel index beyond
// the bank is dropped. A tick item walks all channels in index order, one
// memory read per cycle unless a stalled result holds the pipeline, through
// a four stage update pipeline that writes each channel back to the store,
// and gives one result per channel, the final one marked by last.
// item_stall is high while a tick is in flight, so a new item waits until
// the walk is done and the pipeline has drained.
// A stalled result holds the whole pipeline; the output register lets the
// next item in while the last result of a tick waits.
// Reset clears all channels to zero and empties the pipeline.
module slewed_bouncing_oscillator_bank (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               operation,
	input  logic [3:0]         channel,
	input  logic [7:0]         slew_rate,
	input  logic [3:0]         speed_gain,
	input  logic signed [15:0] position,
	input  logic signed [15:0] speed,
	input  logic signed [15:0] target_speed,
	input  logic signed [7:0]  direction,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [3:0]         channel_index,
	output logic signed [15:0] new_position,
	output logic signed [15:0] new_speed,
	output logic signed [7:0]  new_direction,
	output logic               last
);

	logic                          accept;
	logic                          write_hit;
	logic                          en;
	logic                          busy;
	logic                          issuing_q;
	logic [sbob_pkg::CH_W-1:0]     idx_q;
	logic [7:0]                    slew_q;
	logic [3:0]                    gain_q;
	logic                          result_valid_q;
	logic [3:0]                    chan_idx_q;
	logic signed [15:0]            pos_q;
	logic signed [15:0]            spd_q;
	logic signed [7:0]             dir_q;
	logic                          last_q;

	sbob_pkg::slot_t               issue;
	sbob_pkg::wback_t              wb;
	sbob_pkg::chan_t               rdata;
	sbob_pkg::chan_t               wdata;
	logic                          we;
	logic [sbob_pkg::CH_W-1:0]     waddr;
	logic                          last_idx;

	// input handshake: one item at a time
	assign item_stall = issuing_q | busy;
	assign accept     = item_valid & ~item_stall;
	assign write_hit  = accept && (operation == sbob_pkg::OP_WRITE)
		&& (int'(channel) < sbob_pkg::CHANNELS);

	// pipeline moves whenever the output register is free or being drained
	assign en = ~result_valid_q | ~result_stall;

	assign last_idx    = (int'(idx_q) == sbob_pkg::CHANNELS - 1);
	assign issue.valid = issuing_q;
	assign issue.idx   = idx_q;

	// tick sequencer: one channel read per cycle while the pipeline moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			idx_q     <= '0;
		end else if (accept && (operation == sbob_pkg::OP_TICK)) begin
			issuing_q <= 1'b1;
			idx_q     <= '0;
		end else if (en && issuing_q) begin
			if (last_idx) begin
				issuing_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// tick controls held for the whole walk
	always_ff @(posedge clk) begin
		if (accept && (operation == sbob_pkg::OP_TICK)) begin
			slew_q <= slew_rate;
			gain_q <= speed_gain;
		end
	end

	// store write port: item writes only land while the pipeline is empty
	always_comb begin
		if (write_hit) begin
			we              = 1'b1;
			waddr           = sbob_pkg::CH_W'(channel);
			wdata.position  = position;
			wdata.speed     = speed;
			wdata.target    = target_speed;
			wdata.direction = direction;
		end else begin
			we    = en & wb.valid;
			waddr = wb.idx;
			wdata = wb.data;
		end
	end

	sbob_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (en & issuing_q),
		.raddr  (idx_q),
		.rdata  (rdata)
	);

	sbob_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.issue      (issue),
		.slew_rate  (slew_q),
		.speed_gain (gain_q),
		.rdata      (rdata),
		.wb         (wb),
		.busy       (busy)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= wb.valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (en && wb.valid) begin
			chan_idx_q <= 4'(wb.idx);
			pos_q      <= wb.data.position;
			spd_q      <= wb.data.speed;
			dir_q      <= wb.data.direction;
			last_q     <= (int'(wb.idx) == sbob_pkg::CHANNELS - 1);
		end
	end

	assign result_valid  = result_valid_q;
	assign channel_index = chan_idx_q;
	assign new_position  = pos_q;
	assign new_speed     = spd_q;
	assign new_direction = dir_q;
	assign last          = last_q;

endmodule

@@ rtl/sbob_check.sv @@
// port level checks of the oscillator bank and their binding
module sbob_check (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               operation,
	input logic               result_valid,
	input logic               result_stall,
	input logic [3:0]         channel_index,
	input logic signed [15:0] new_position,
	input logic               last
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its position
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(new_position))
		else $error("result payload changed while stalled");

	// a tick blocks the item channel in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (operation == sbob_pkg::OP_TICK) |=> item_stall)
		else $error("tick not followed by busy");

	// the final result of a tick reports the final channel
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> (channel_index == 4'(sbob_pkg::CHANNELS - 1)))
		else $error("last on wrong channel");

	// a write item never yields a result in the next cycle when the output is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && item_valid && !item_stall && (operation == sbob_pkg::OP_WRITE)
		|=> !result_valid)
		else $error("result from a write item");

endmodule

bind slewed_bouncing_oscillator_bank sbob_check u_sbob_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item_valid),
	.item_stall    (item_stall),
	.operation     (operation),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.channel_index (channel_index),
	.new_position  (new_position),
	.last          (last)
);
